// File: design/svf_pkg.sv
// Shared widths, item and configuration types, and saturation helpers
// for the state-variable filter. No dependencies.
package svf_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int STATE_W     = 32;
    localparam int COEF_W      = 24;
    localparam int MIX_W       = 18;
    localparam int COEF_FRAC   = 20;
    localparam int MIX_FRAC    = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = COEF_W;
    localparam int SUM_W       = SAMPLE_W + 1;
    localparam int WIDE_W      = (STATE_W > SAMPLE_W) ? STATE_W : SAMPLE_W;
    localparam int V3_W        = WIDE_W + 2;
    localparam int MAG_W       = V3_W;
    localparam int CM_W        = COEF_W + 1;
    localparam int PROD_W      = MAG_W + CM_W;
    localparam int TERM_W      = PROD_W + 2 - MIX_FRAC;
    localparam int ACC_W       = TERM_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        [COEF_W-1:0] g1;
        logic        [COEF_W-1:0] g2;
        logic        [COEF_W-1:0] g3;
        logic        [COEF_W-1:0] rq;
        logic signed [MIX_W-1:0]  low_mix;
        logic signed [MIX_W-1:0]  high_mix;
        logic signed [MIX_W-1:0]  band_mix;
        logic signed [MIX_W-1:0]  reject_mix;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SUM_W-1:0]    sum;
    } t_item;

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-STATE_W:0] top_bits;
        top_bits = v[ACC_W-1:STATE_W-1];
        if (top_bits == '0 || top_bits == '1) begin
            sat_state = v[STATE_W-1:0];
        end else if (v[ACC_W-1]) begin
            sat_state = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            sat_state = {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-SAMPLE_W:0] top_bits;
        top_bits = v[ACC_W-1:SAMPLE_W-1];
        if (top_bits == '0 || top_bits == '1) begin
            sat_sample = v[SAMPLE_W-1:0];
        end else if (v[ACC_W-1]) begin
            sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: design/svf_front.sv
// Input side of the filter: accepts samples, keeps the previous sample and
// forms their sum, and queues items for the back end. Uses svf_pkg.
module svf_front import svf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_item_vld,
    output t_item                      o_item,
    input  logic                       i_item_take
);

    logic signed [SAMPLE_W-1:0] r_prev;
    t_item                      r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]          r_wr_ptr;
    logic [QPTR_W-1:0]          r_rd_ptr;
    logic [QPTR_W:0]            r_count;
    logic                       accept;
    logic                       take;
    t_item                      new_item;

    assign o_full     = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_item_vld = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign accept     = i_push && !o_full;
    assign take       = i_item_take && o_item_vld;

    always_comb begin
        new_item.x   = i_sample_in;
        new_item.sum = {i_sample_in[SAMPLE_W-1], i_sample_in} + {r_prev[SAMPLE_W-1], r_prev};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_mem[r_wr_ptr] <= new_item;
                r_prev          <= i_sample_in;
                r_wr_ptr        <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (accept && !take) begin
                r_count <= r_count + 1'b1;
            end else if (take && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/svf_back.sv
// Back end of the filter: sequencer, shared rounding multiplier pipeline,
// integrator states and the output register. Uses svf_pkg.
module svf_back import svf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_item_vld,
    input  t_item                      i_item,
    output logic                       o_item_take,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [SAMPLE_W-1:0] o_sample_out
);

    typedef enum logic [2:0] {
        S_IDLE, S_COEF, S_UPD, S_DAMP, S_SPLIT, S_MIX, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        DST_BAND, DST_LOW, DST_DAMP, DST_OUT
    } t_dst;

    localparam logic [3:0] OP_G1     = 4'd0;
    localparam logic [3:0] OP_G2     = 4'd1;
    localparam logic [3:0] OP_G3     = 4'd2;
    localparam logic [3:0] OP_G4     = 4'd3;
    localparam logic [3:0] OP_DAMP   = 4'd4;
    localparam logic [3:0] OP_LOW    = 4'd5;
    localparam logic [3:0] OP_HIGH   = 4'd6;
    localparam logic [3:0] OP_BAND   = 4'd7;
    localparam logic [3:0] OP_REJECT = 4'd8;
    localparam logic [3:0] OP_END    = 4'd9;

    localparam logic [PROD_W:0] HALF_COEF = (PROD_W+1)'(1) << (COEF_FRAC-1);
    localparam logic [PROD_W:0] HALF_MIX  = (PROD_W+1)'(1) << (MIX_FRAC-1);

    function automatic logic signed [V3_W-1:0] ext_state(input logic signed [STATE_W-1:0] v);
        ext_state = {{(V3_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_state(input logic signed [STATE_W-1:0] v);
        acc_state = {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    function automatic logic [CM_W-1:0] mix_mag(input logic signed [MIX_W-1:0] m);
        logic [MIX_W-1:0] u;
        u = m[MIX_W-1] ? (~m + 1'b1) : m;
        mix_mag = {{(CM_W-MIX_W){1'b0}}, u};
    endfunction

    t_state                     r_state;
    logic [3:0]                 r_op;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [V3_W-1:0]     r_v3;
    logic signed [STATE_W-1:0]  r_band;
    logic signed [STATE_W-1:0]  r_low;
    logic signed [STATE_W-1:0]  r_hp;
    logic signed [STATE_W-1:0]  r_br;
    logic signed [ACC_W-1:0]    r_acc_band;
    logic signed [ACC_W-1:0]    r_acc_low;
    logic signed [ACC_W-1:0]    r_acc_damp;
    logic signed [ACC_W-1:0]    r_acc_out;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_vld;

    logic                       r_s1_vld;
    logic [MAG_W-1:0]           r_s1_a;
    logic [CM_W-1:0]            r_s1_c;
    logic                       r_s1_neg;
    logic                       r_s1_mix;
    t_dst                       r_s1_dst;
    logic                       r_s2_vld;
    logic [PROD_W-1:0]          r_s2_prod;
    logic                       r_s2_neg;
    logic                       r_s2_mix;
    t_dst                       r_s2_dst;
    logic                       r_s3_vld;
    logic signed [ACC_W-1:0]    r_s3_term;
    t_dst                       r_s3_dst;

    logic                       issue;
    logic                       pipe_busy;
    logic signed [V3_W-1:0]     op_a;
    logic [CM_W-1:0]            op_c;
    logic                       op_gneg;
    logic                       op_mix;
    t_dst                       op_dst;
    logic [MAG_W-1:0]           a_mag;
    logic [PROD_W:0]            rnd_sum;
    logic [TERM_W-2:0]          term_mag;
    logic signed [ACC_W-1:0]    term_ext;
    logic signed [V3_W-1:0]     sum_ext;
    logic signed [V3_W-1:0]     low_twice;
    logic signed [ACC_W-1:0]    x_ext;
    logic signed [ACC_W-1:0]    x_damped;

    assign issue = (r_state == S_COEF && r_op != OP_DAMP)
                || (r_state == S_DAMP && r_op != OP_LOW)
                || (r_state == S_MIX  && r_op != OP_END);
    assign pipe_busy    = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_item_take  = (r_state == S_IDLE) && i_item_vld;
    assign o_empty      = !r_out_vld;
    assign o_sample_out = r_out;

    assign sum_ext   = {{(V3_W-SUM_W){i_item.sum[SUM_W-1]}}, i_item.sum};
    assign low_twice = {{(V3_W-STATE_W-1){r_low[STATE_W-1]}}, r_low, 1'b0};
    assign x_ext     = {{(ACC_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
    assign x_damped  = x_ext - r_acc_damp;

    always_comb begin
        op_a    = '0;
        op_c    = '0;
        op_gneg = 1'b0;
        op_mix  = 1'b0;
        op_dst  = DST_BAND;
        unique case (r_op)
            OP_G1: begin
                op_a = r_v3;
                op_c = {1'b0, i_cfg.g1};
            end
            OP_G2: begin
                op_a    = ext_state(r_band);
                op_c    = {1'b0, i_cfg.g2};
                op_gneg = 1'b1;
            end
            OP_G3: begin
                op_a   = r_v3;
                op_c   = {1'b0, i_cfg.g3};
                op_dst = DST_LOW;
            end
            OP_G4: begin
                op_a   = ext_state(r_band);
                op_c   = {i_cfg.g1, 1'b0};
                op_dst = DST_LOW;
            end
            OP_DAMP: begin
                op_a   = ext_state(r_band);
                op_c   = {1'b0, i_cfg.rq};
                op_dst = DST_DAMP;
            end
            OP_LOW: begin
                op_a    = ext_state(r_low);
                op_c    = mix_mag(i_cfg.low_mix);
                op_gneg = i_cfg.low_mix[MIX_W-1];
                op_mix  = 1'b1;
                op_dst  = DST_OUT;
            end
            OP_HIGH: begin
                op_a    = ext_state(r_hp);
                op_c    = mix_mag(i_cfg.high_mix);
                op_gneg = i_cfg.high_mix[MIX_W-1];
                op_mix  = 1'b1;
                op_dst  = DST_OUT;
            end
            OP_BAND: begin
                op_a    = ext_state(r_band);
                op_c    = mix_mag(i_cfg.band_mix);
                op_gneg = i_cfg.band_mix[MIX_W-1];
                op_mix  = 1'b1;
                op_dst  = DST_OUT;
            end
            OP_REJECT: begin
                op_a    = ext_state(r_br);
                op_c    = mix_mag(i_cfg.reject_mix);
                op_gneg = i_cfg.reject_mix[MIX_W-1];
                op_mix  = 1'b1;
                op_dst  = DST_OUT;
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    assign a_mag = op_a[V3_W-1] ? (~op_a + 1'b1) : op_a;

    // Products are rounded on the magnitude, halves away from zero.
    always_comb begin
        rnd_sum  = {1'b0, r_s2_prod} + (r_s2_mix ? HALF_MIX : HALF_COEF);
        term_mag = r_s2_mix ? rnd_sum[PROD_W:MIX_FRAC] : (TERM_W-1)'(rnd_sum >> COEF_FRAC);
        term_ext = {{(ACC_W-TERM_W+1){1'b0}}, term_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
        r_s1_a    <= a_mag;
        r_s1_c    <= op_c;
        r_s1_neg  <= op_a[V3_W-1] ^ op_gneg;
        r_s1_mix  <= op_mix;
        r_s1_dst  <= op_dst;
        r_s2_prod <= r_s1_a * r_s1_c;
        r_s2_neg  <= r_s1_neg;
        r_s2_mix  <= r_s1_mix;
        r_s2_dst  <= r_s1_dst;
        r_s3_term <= r_s2_neg ? -term_ext : term_ext;
        r_s3_dst  <= r_s2_dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_G1;
            r_band    <= '0;
            r_low     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_pop && r_out_vld && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            if (issue) begin
                r_op <= r_op + 4'd1;
            end
            if (r_s3_vld) begin
                unique case (r_s3_dst)
                    DST_BAND: r_acc_band <= r_acc_band + r_s3_term;
                    DST_LOW:  r_acc_low  <= r_acc_low + r_s3_term;
                    DST_DAMP: r_acc_damp <= r_acc_damp + r_s3_term;
                    DST_OUT:  r_acc_out  <= r_acc_out + r_s3_term;
                    default:  r_acc_out  <= r_acc_out;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_vld) begin
                        r_x        <= i_item.x;
                        r_v3       <= sum_ext - low_twice;
                        r_acc_band <= acc_state(r_band);
                        r_acc_low  <= acc_state(r_low);
                        r_op       <= OP_G1;
                        r_state    <= S_COEF;
                    end
                end
                S_COEF: begin
                    if (!issue && !pipe_busy) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_band     <= sat_state(r_acc_band);
                    r_low      <= sat_state(r_acc_low);
                    r_acc_damp <= '0;
                    r_state    <= S_DAMP;
                end
                S_DAMP: begin
                    if (!issue && !pipe_busy) begin
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    r_br      <= sat_state(x_damped);
                    r_hp      <= sat_state(x_damped - acc_state(r_low));
                    r_acc_out <= '0;
                    r_state   <= S_MIX;
                end
                S_MIX: begin
                    if (!issue && !pipe_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || i_pop) begin
                        r_out     <= sat_sample(r_acc_out);
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/state_variable_filter_mix.sv
// Top level of the trapezoidal state-variable filter with output mix.
// Holds the configuration registers and connects svf_front and svf_back.
// Uses svf_pkg.
//
// Each item is one signed Q1.23 sample and gives one mixed Q1.23 result.
// In the back end, nine rounded products run one after another through
// a single multiply pipeline, in three dependent groups (integrator
// update, damping, output mix), each group waiting for the pipeline to
// drain. Two items can wait in the input queue and one finished result
// in the output register. Coefficients are unsigned Q4.20, mix gains
// signed Q2.16, and the fourth gain is twice g1. Write the registers
// only while the block is idle.
module state_variable_filter_mix import svf_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [SAMPLE_W-1:0]   i_sample_in,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [SAMPLE_W-1:0]   o_sample_out,
    input  logic                         valid,
    output logic                         ready,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_G1, REG_G2, REG_G3, REG_DAMPING,
        REG_LOW_MIX, REG_HIGH_MIX, REG_BAND_MIX, REG_REJECT_MIX
    } t_reg_idx;

    t_cfg  r_cfg;
    logic  item_vld;
    t_item item;
    logic  item_take;

    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.g1         <= '0;
            r_cfg.g2         <= '0;
            r_cfg.g3         <= '0;
            r_cfg.rq         <= '0;
            r_cfg.low_mix    <= {2'b01, {(MIX_W-2){1'b0}}};
            r_cfg.high_mix   <= '0;
            r_cfg.band_mix   <= '0;
            r_cfg.reject_mix <= '0;
        end else if (valid && ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_G1:         r_cfg.g1         <= i_cfg_data[COEF_W-1:0];
                REG_G2:         r_cfg.g2         <= i_cfg_data[COEF_W-1:0];
                REG_G3:         r_cfg.g3         <= i_cfg_data[COEF_W-1:0];
                REG_DAMPING:    r_cfg.rq         <= i_cfg_data[COEF_W-1:0];
                REG_LOW_MIX:    r_cfg.low_mix    <= i_cfg_data[MIX_W-1:0];
                REG_HIGH_MIX:   r_cfg.high_mix   <= i_cfg_data[MIX_W-1:0];
                REG_BAND_MIX:   r_cfg.band_mix   <= i_cfg_data[MIX_W-1:0];
                REG_REJECT_MIX: r_cfg.reject_mix <= i_cfg_data[MIX_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    svf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_sample_in (i_sample_in),
        .o_item_vld  (item_vld),
        .o_item      (item),
        .i_item_take (item_take)
    );

    svf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_vld   (item_vld),
        .i_item       (item),
        .o_item_take  (item_take),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_sample_out (o_sample_out)
    );

endmodule
